@@ design/barometer_raw_compensation_defines.svh @@
// Assertion macros for the barometer compensation checker
`ifndef BAROMETER_RAW_COMPENSATION_DEFINES_SVH
`define BAROMETER_RAW_COMPENSATION_DEFINES_SVH
// implication checked on every edge outside reset
`define BRC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
// next-cycle implication
`define BRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`endif

@@ design/brc_pkg.sv @@
// Shared types, constants and helpers for the barometer compensation block
package brc_pkg;
  localparam logic [1:0] CFG_PRESSURE  = 2'd0;
  localparam logic [1:0] CFG_TEMP      = 2'd1;
  localparam logic [1:0] CFG_QUADRATIC = 2'd2;
  localparam logic [1:0] CFG_OSS       = 2'd3;

  localparam logic OP_TEMPERATURE = 1'b0;
  localparam logic OP_PRESSURE    = 1'b1;

  // datapath micro-operations
  localparam logic [3:0] CMD_NONE  = 4'd0;
  localparam logic [3:0] CMD_LOAD  = 4'd1;
  localparam logic [3:0] CMD_STEP  = 4'd2;
  localparam logic [3:0] CMD_DSTART = 4'd3;
  localparam logic [3:0] CMD_DITER = 4'd4;
  localparam logic [3:0] CMD_FIN   = 4'd5;

  localparam int DivSteps = 32;
  localparam logic [31:0] K_B6      = 32'd4000;
  localparam logic [31:0] K_X1      = 32'd3038;
  localparam logic [31:0] K_X2      = 32'hFFFF_E343; // -7357
  localparam logic [31:0] K_ROUND   = 32'd3791;
  localparam logic [31:0] K_PSCALE  = 32'd50000;
  localparam logic [31:0] K_HALF    = 32'd32768;
  localparam logic [31:0] K_SIGN    = 32'h8000_0000;

  typedef struct packed {
    logic [3:0] cmd;
    logic [3:0] step;
  } brc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic zero_div;
  } brc_stat_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
    asr = 32'($signed(v) >>> s);
  endfunction
endpackage

@@ design/brc_datapath.sv @@
// Datapath: calibration registers, step sequence registers and a restoring divider
module brc_datapath import brc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        operation,
  input  logic [23:0] raw_reading,
  input  brc_cmd_t    ctl,
  output brc_stat_t   stat,
  output logic        result_kind,
  output logic [27:0] temperature_tenths_c,
  output logic [31:0] pressure_pa,
  output logic        divide_fault
);
  logic [63:0] cal_p, cal_t;
  logic [31:0] cal_q;
  logic [1:0]  oss;
  logic [31:0] b5;
  logic        op;
  logic [23:0] raw;
  logic [31:0] r0, r1, r2, r3, r4, r5, r6, r7;
  logic [31:0] num, den, quo, rem;
  logic [5:0]  dcnt;
  logic        dneg, zero;
  logic [32:0] rsh;
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, mc, md, b1, b2;
  logic [31:0] prod, nabs, dabs;

  assign ac1 = sx16(cal_p[63:48]);
  assign ac2 = sx16(cal_p[47:32]);
  assign ac3 = sx16(cal_p[31:16]);
  assign ac4 = {16'd0, cal_p[15:0]};
  assign ac5 = {16'd0, cal_t[63:48]};
  assign ac6 = {16'd0, cal_t[47:32]};
  assign mc  = sx16(cal_t[31:16]);
  assign md  = sx16(cal_t[15:0]);
  assign b1  = sx16(cal_q[31:16]);
  assign b2  = sx16(cal_q[15:0]);
  assign nabs = num[31] ? 32'(-num) : num;
  assign dabs = den[31] ? 32'(-den) : den;
  assign rsh = {rem, quo[31]};
  assign stat.div_done = (dcnt == 6'd0);
  assign stat.zero_div = zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_p <= '0; cal_t <= '0; cal_q <= '0; oss <= '0; b5 <= '0;
      dcnt <= '0; zero <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_PRESSURE:  cal_p <= cfg_data;
          CFG_TEMP:      cal_t <= cfg_data;
          CFG_QUADRATIC: cal_q <= cfg_data[31:0];
          CFG_OSS:       oss   <= cfg_data[1:0];
          default: ;
        endcase
      end
      case (ctl.cmd)
        CMD_LOAD: begin
          op <= operation; raw <= raw_reading; zero <= 1'b0;
          r0 <= b5 - K_B6;
        end
        CMD_STEP: begin
          // at most two multiplies per step, registered
          if (op == OP_TEMPERATURE) begin
            case (ctl.step)
              4'd0: r1 <= 32'(({16'd0, raw[15:0]} - ac6) * ac5);
              4'd1: begin r1 <= asr(r1, 5'd15); r2 <= mc << 11; end
              default: begin num <= r2; den <= r1 + md; end
            endcase
          end else begin
            case (ctl.step)
              4'd0: r1 <= 32'(r0 * r0);
              4'd1: begin r1 <= asr(r1, 5'd12); r2 <= 32'(ac2 * r0); end
              4'd2: begin r3 <= 32'(b2 * r1); r4 <= 32'(ac3 * r0); end
              4'd3: begin r5 <= 32'(b1 * r1);
                r3 <= asr(r3, 5'd11) + asr(r2, 5'd11); end
              4'd4: begin r2 <= asr(32'(((ac1 << 2) + r3) << oss) + 32'd2, 5'd2);
                r4 <= asr(asr(r4, 5'd13) + asr(r5, 5'd16) + 32'd2, 5'd2); end
              4'd5: begin r4 <= 32'(ac4 * (r4 + K_HALF));
                r6 <= ({8'd0, raw} >> (4'd8 - {2'd0, oss})) - r2; end
              4'd6: begin r4 <= r4 >> 15; r6 <= 32'(r6 * (K_PSCALE >> oss)); end
              default: begin
                num <= (r6 < K_SIGN) ? r6 << 1 : r6; den <= r4;
              end
            endcase
          end
        end
        CMD_DSTART: begin
          zero <= (den == 32'd0);
          // temperature is signed, pressure unsigned
          dneg <= (op == OP_TEMPERATURE) && (num[31] ^ den[31]);
          if (op == OP_TEMPERATURE) begin quo <= nabs; den <= dabs; end
          else quo <= num;
          rem <= '0;
          dcnt <= 6'(DivSteps);
        end
        CMD_DITER: begin
          if (rsh >= {1'b0, den}) begin
            rem <= 32'(rsh - {1'b0, den}); quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= rsh[31:0]; quo <= {quo[30:0], 1'b0};
          end
          dcnt <= dcnt - 6'd1;
        end
        CMD_FIN: begin
          if (op == OP_TEMPERATURE) begin
            case (ctl.step)
              4'd0: if (!zero) b5 <= r1 + (dneg ? 32'(-quo) : quo);
              default: ;
            endcase
          end else begin
            case (ctl.step)
              4'd0: begin
                r7 <= (r6 < K_SIGN) ? quo : quo << 1;
                r1 <= 32'(asr((r6 < K_SIGN) ? quo : quo << 1, 5'd8) *
                          asr((r6 < K_SIGN) ? quo : quo << 1, 5'd8));
              end
              4'd1: begin r1 <= 32'(r1 * K_X1); r2 <= 32'(K_X2 * r7); end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  logic [31:0] tsum, ptot;
  assign tsum = asr(b5 + 32'd8, 5'd4);
  assign ptot = r7 + asr(asr(r1, 5'd16) + asr(r2, 5'd16) + K_ROUND, 5'd4);

  // output register, loaded on the final step
  always_ff @(posedge clk) begin
    if (ctl.cmd == CMD_FIN && ctl.step == 4'd2) begin
      result_kind  <= op;
      divide_fault <= zero;
      temperature_tenths_c <= (op == OP_TEMPERATURE && !zero) ? tsum[27:0] : '0;
      pressure_pa  <= (op == OP_PRESSURE && !zero) ? ptot : '0;
    end
  end
endmodule

@@ design/brc_control.sv @@
// Controller: sequences load, multiply steps, division and finish
module brc_control import brc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      operation,
  output logic      out_valid,
  input  logic      out_ready,
  input  brc_stat_t stat,
  output brc_cmd_t  ctl
);
  localparam logic [2:0] S_IDLE = 3'd0, S_STEP = 3'd1, S_DST = 3'd2,
                         S_DIV = 3'd3, S_FIN = 3'd4;
  logic [2:0] state, state_next;
  logic [3:0] step, step_next;
  logic       is_p;
  logic [3:0] last;

  assign last = is_p ? 4'd7 : 4'd2;
  // accept when idle and the output register is empty or its held result goes out this cycle
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state; step_next = step; ctl.cmd = CMD_NONE; ctl.step = step;
    unique case (state)
      S_IDLE: if (in_valid && in_ready) begin
        ctl.cmd = CMD_LOAD; state_next = S_STEP; step_next = '0;
      end
      S_STEP: begin
        ctl.cmd = CMD_STEP; step_next = step + 4'd1;
        if (step == last) state_next = S_DST;
      end
      S_DST: begin ctl.cmd = CMD_DSTART; state_next = S_DIV; end
      S_DIV: begin
        if (stat.div_done) begin state_next = S_FIN; step_next = '0; end
        else ctl.cmd = CMD_DITER;
      end
      S_FIN: begin
        ctl.cmd = CMD_FIN; step_next = step + 4'd1;
        if (step == 4'd2) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; step <= '0; out_valid <= 1'b0; is_p <= 1'b0;
    end else begin
      state <= state_next; step <= step_next;
      if (in_valid && in_ready) is_p <= (operation == OP_PRESSURE);
      if (state == S_FIN && step == 4'd2) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule

@@ design/barometer_raw_compensation.sv @@
// One transaction at a time: no new input is taken until the current one has passed
// through the multiply steps, the 32-step restoring divider and the finish steps.
// The next input is taken once the output register is empty or being read.
// Synchronous reset clears calibration, oversampling and the stored temperature term.
// Configuration writes are always accepted.
module barometer_raw_compensation import brc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [23:0] raw_reading,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic signed [27:0] temperature_tenths_c,
  output logic signed [31:0] pressure_pa,
  output logic        divide_fault
);
  brc_cmd_t  ctl;
  brc_stat_t stat;
  logic [27:0] t_u;
  logic [31:0] p_u;

  assign cfg_ready = 1'b1;
  assign temperature_tenths_c = $signed(t_u);
  assign pressure_pa = $signed(p_u);

  brc_control u_ctl (
    .clk, .rst, .in_valid, .in_ready, .operation,
    .out_valid, .out_ready, .stat, .ctl
  );

  brc_datapath u_dp (
    .clk, .rst, .cfg_valid, .cfg_index, .cfg_data, .operation, .raw_reading,
    .ctl, .stat, .result_kind, .temperature_tenths_c(t_u), .pressure_pa(p_u),
    .divide_fault
  );
endmodule

@@ design/brc_checker.sv @@
// Port-level checker for the barometer compensation block, bound to the top level
`include "barometer_raw_compensation_defines.svh"
module brc_checker import brc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        result_kind,
  input logic [31:0] pressure_pa,
  input logic [27:0] temperature_tenths_c,
  input logic        divide_fault
);
  `BRC_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `BRC_ASSERT_NEXT(a_out_held, clk, rst, out_valid && !out_ready, out_valid && $stable(pressure_pa))
  `BRC_ASSERT_IMP(a_fault_zero, clk, rst, out_valid && divide_fault, pressure_pa == 32'd0 && temperature_tenths_c == 28'd0)
  `BRC_ASSERT_IMP(a_temp_no_p, clk, rst, out_valid && result_kind == OP_TEMPERATURE, pressure_pa == 32'd0)
endmodule

bind barometer_raw_compensation brc_checker u_brc_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .result_kind,
  .pressure_pa, .temperature_tenths_c, .divide_fault
);
